// ----- rtl/core/sfd_pkg.sv -----
// Shared types and constants for the serial frame delimiter.
// Used by sfd_cfg, sfd_frame, sfd_out and serial_frame_delimiter.
// No dependencies.
package sfd_pkg;

  // Field widths
  localparam int BYTE_W      = 8;
  localparam int MODE_W      = 2;
  localparam int TICKS_W     = 16;
  localparam int STOP_LEN_W  = 3;
  localparam int STOP_SEQ_W  = 32;
  localparam int STOP_SEQ_BYTES = STOP_SEQ_W / BYTE_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // Defaults
  localparam int MAX_STOP_DEFAULT = 4;
  localparam logic [TICKS_W-1:0] IDLE_TICKS_RESET = TICKS_W'(10);

  // Framing modes
  localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_IDLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TICKS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_LENGTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_SEQUENCE = 2'd3;

  // Input kinds
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Register file contents seen by the framing logic
  typedef struct packed {
    logic [MODE_W-1:0]     frame_mode;
    logic [TICKS_W-1:0]    idle_ticks;
    logic [STOP_LEN_W-1:0] stop_length;
    logic [STOP_SEQ_W-1:0] stop_sequence;
    logic                  match_clr;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              frame_last;
  } res_t;

endpackage

// ----- rtl/core/sfd_cfg.sv -----
// Configuration registers of the serial frame delimiter.
// Depends on sfd_pkg.
module sfd_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data,
  output sfd_pkg::cfg_t                  cfg
);
  import sfd_pkg::*;

  logic [MODE_W-1:0]     frame_mode;
  logic [TICKS_W-1:0]    idle_ticks;
  logic [STOP_LEN_W-1:0] stop_length;
  logic [STOP_SEQ_W-1:0] stop_sequence;
  logic                  wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  // Write one register per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode    <= MODE_PASS;
      idle_ticks    <= IDLE_TICKS_RESET;
      stop_length   <= '0;
      stop_sequence <= '0;
    end else if (wr) begin
      unique case (cfg_index)
        REG_FRAME_MODE:    frame_mode    <= cfg_data[MODE_W-1:0];
        REG_IDLE_TICKS:    idle_ticks    <= cfg_data[TICKS_W-1:0];
        REG_STOP_LENGTH:   stop_length   <= cfg_data[STOP_LEN_W-1:0];
        REG_STOP_SEQUENCE: stop_sequence <= cfg_data[STOP_SEQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Restart the match on every write to the stop length or stop sequence
  always_comb begin
    cfg.frame_mode    = frame_mode;
    cfg.idle_ticks    = idle_ticks;
    cfg.stop_length   = stop_length;
    cfg.stop_sequence = stop_sequence;
    cfg.match_clr     = wr && (cfg_index == REG_STOP_LENGTH ||
                               cfg_index == REG_STOP_SEQUENCE);
  end

endmodule

// ----- rtl/core/sfd_frame.sv -----
// Per-item framing logic: holds idle-mode byte, idle counter and match position.
// Depends on sfd_pkg.
module sfd_frame #(
  parameter int MAX_STOP = sfd_pkg::MAX_STOP_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic                       func,
  input  logic [sfd_pkg::BYTE_W-1:0] rx_byte,
  input  sfd_pkg::cfg_t              cfg,
  output logic                       res_valid,
  output sfd_pkg::res_t              res
);
  import sfd_pkg::*;

  localparam int POS_W = $clog2(MAX_STOP + 1);

  logic [BYTE_W-1:0]  held_byte, held_byte_next;
  logic               held_valid, held_valid_next;
  logic [TICKS_W-1:0] idle_count, idle_count_next;
  logic [POS_W-1:0]   match_pos, match_pos_next;

  logic [POS_W-1:0]   len;
  logic [POS_W-1:0]   pos_cur;
  logic [POS_W-1:0]   pos_new;
  logic [BYTE_W-1:0]  stop_at_pos;
  logic [BYTE_W-1:0]  stop_first;
  logic [TICKS_W:0]   limit;
  logic [TICKS_W:0]   count_inc;
  logic [MODE_W-1:0]  mode;
  logic [BYTE_W-1:0]  stop_bytes [MAX_STOP];

  // Saturate the stop length to the supported depth
  always_comb begin
    if (32'(cfg.stop_length) > MAX_STOP) len = POS_W'(MAX_STOP);
    else                                 len = POS_W'(cfg.stop_length);
  end

  // Unpack stop bytes; positions past the register read as zero
  always_comb begin
    for (int i = 0; i < MAX_STOP; i++) begin
      if (i < STOP_SEQ_BYTES) stop_bytes[i] = cfg.stop_sequence[BYTE_W*i +: BYTE_W];
      else                    stop_bytes[i] = '0;
    end
  end

  // Select the stop byte expected at the current match position
  always_comb begin
    pos_cur     = (match_pos >= len) ? '0 : match_pos;
    stop_at_pos = '0;
    for (int i = 0; i < MAX_STOP; i++) begin
      if (pos_cur == POS_W'(i)) stop_at_pos = stop_bytes[i];
    end
    stop_first = stop_bytes[0];
    if (rx_byte == stop_at_pos)     pos_new = pos_cur + POS_W'(1);
    else if (rx_byte == stop_first) pos_new = POS_W'(1);
    else                            pos_new = '0;
  end

  // Empty stop sequence falls back to idle framing
  always_comb begin
    mode = cfg.frame_mode;
    if (mode == MODE_STOP && len == '0) mode = MODE_IDLE;
  end

  assign limit     = (cfg.idle_ticks == '0) ? (TICKS_W+1)'(1) : {1'b0, cfg.idle_ticks};
  assign count_inc = {1'b0, idle_count} + (TICKS_W+1)'(1);

  // Decide the result and next state for one item
  always_comb begin
    held_byte_next  = held_byte;
    held_valid_next = held_valid;
    idle_count_next = idle_count;
    match_pos_next  = match_pos;
    res_valid       = 1'b0;
    res.out_byte    = rx_byte;
    res.frame_last  = 1'b1;
    if (func == FUNC_TICK) begin
      if (held_valid) begin
        if (count_inc >= limit) begin
          res_valid       = 1'b1;
          res.out_byte    = held_byte;
          held_valid_next = 1'b0;
          idle_count_next = '0;
        end else begin
          idle_count_next = count_inc[TICKS_W-1:0];
        end
      end
    end else begin
      unique case (mode)
        MODE_IDLE: begin
          res_valid       = held_valid;
          res.out_byte    = held_byte;
          res.frame_last  = 1'b0;
          held_byte_next  = rx_byte;
          held_valid_next = 1'b1;
          idle_count_next = '0;
        end
        MODE_STOP: begin
          res_valid = 1'b1;
          if (pos_new >= len) begin
            match_pos_next = '0;
          end else begin
            match_pos_next = pos_new;
            res.frame_last = 1'b0;
          end
        end
        default: res_valid = 1'b1;
      endcase
    end
  end

  // Advance state on each accepted transaction; a stop length or sequence write clears the match position
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_byte  <= '0;
      idle_count <= '0;
      match_pos  <= '0;
    end else begin
      if (accept) begin
        held_valid <= held_valid_next;
        held_byte  <= held_byte_next;
        idle_count <= idle_count_next;
      end
      if (cfg.match_clr)   match_pos <= '0;
      else if (accept)     match_pos <= match_pos_next;
    end
  end

  // Counter only runs while a byte is held
  a_idle_cnt_zero: assert property (@(posedge clk) disable iff (rst)
    !held_valid |-> idle_count == '0)
    else $error("idle counter running with nothing held");

  // Stored match position stays below the maximum stop depth
  a_match_bound: assert property (@(posedge clk) disable iff (rst)
    match_pos < POS_W'(MAX_STOP))
    else $error("match position out of range");

  // A tick with nothing held produces no result
  a_tick_empty: assert property (@(posedge clk) disable iff (rst)
    (accept && func == FUNC_TICK && !held_valid) |-> !res_valid)
    else $error("result from tick with nothing held");

endmodule

// ----- rtl/core/sfd_out.sv -----
// Output register of the serial frame delimiter; drives the master stream.
// Depends on sfd_pkg.
module sfd_out (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  sfd_pkg::res_t              res,
  output logic                       room,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [sfd_pkg::BYTE_W-1:0] m_tdata,
  output logic                       m_tlast
);
  import sfd_pkg::*;

  // Register is free when empty or being drained this cycle
  assign room = !m_tvalid || m_tready;

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (room) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && room) begin
      m_tdata <= res.out_byte;
      m_tlast <= res.frame_last;
    end
  end

  // Loading only happens when there is space
  a_load_room: assert property (@(posedge clk) disable iff (rst)
    load |-> room)
    else $error("result loaded over a pending transaction");

  // A loaded result is presented next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> m_tvalid)
    else $error("loaded result not presented");

  // Output drops only after a completed transaction
  a_drop_after_take: assert property (@(posedge clk) disable iff (rst)
    $fell(m_tvalid) |-> $past(m_tready))
    else $error("result dropped without transaction");

endmodule

// ----- rtl/core/serial_frame_delimiter.sv -----
// Serial frame delimiter top level: splits a byte stream into frames.
// Depends on sfd_pkg, sfd_cfg, sfd_frame, sfd_out.
//
// Usage:
//   Slave stream s_*: s_tdata carries a received byte, s_tuser says what the
//   transaction is (0 a byte, 1 one idle time tick elapsed).
//   Master stream m_*: m_tdata is the byte passed on, m_tlast marks the last
//   byte of a frame. A transaction in yields zero or one transaction out.
//   Config channel cfg_*: index 0 frame_mode, 1 idle_ticks, 2 stop_length,
//   3 stop_sequence; always ready. Write only while the block is idle.
// Timing:
//   One input transaction per cycle while m_* is not stalled; its result appears on m_* the cycle
//   after it is accepted. All per-item work is a byte compare and a 16-bit
//   counter step between the slave handshake and the output register.
// Reset:
//   rst clears held byte, idle counter and match position, and sets the
//   registers to pass-through mode, 10 idle ticks, no stop sequence.
// Backpressure:
//   While m_tready is low and a result is pending, s_tready drops; no item
//   is taken or lost until the output register drains.
module serial_frame_delimiter #(
  parameter int MAX_STOP = sfd_pkg::MAX_STOP_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [sfd_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] rx_byte
  input  logic                           s_tuser,   // [0] func
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sfd_pkg::BYTE_W-1:0]     m_tdata,   // [7:0] out_byte
  output logic                           m_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sfd_pkg::*;

  cfg_t cfg;
  res_t res;
  logic res_valid;
  logic room;
  logic accept;

  assign s_tready = room;
  assign accept   = s_tvalid && s_tready;

  sfd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfd_frame #(
    .MAX_STOP (MAX_STOP)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .func      (s_tuser),
    .rx_byte   (s_tdata),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  sfd_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && res_valid),
    .res      (res),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for serial_frame_delimiter: directed table, then random framing traffic.
// Tracks the block's behavior in a local predictor and checks every output transaction.
// Depends on sfd_pkg and the serial_frame_delimiter RTL.
`timescale 1ns / 1ps

module tb;
  import sfd_pkg::*;

  localparam int MAX_STOP = MAX_STOP_DEFAULT;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;

  typedef enum logic {ROW_REG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic                  func;
    logic [BYTE_W-1:0]     data;
    logic                  typed;
    res_t                  exp;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [BYTE_W-1:0] s_tdata;     // [7:0] rx_byte
  logic s_tuser;                  // [0] func
  logic m_tvalid;
  logic m_tready;
  logic [BYTE_W-1:0] m_tdata;     // [7:0] out_byte
  logic m_tlast;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor copy of registers and framing state
  logic [MODE_W-1:0]     mdl_mode;
  logic [TICKS_W-1:0]    mdl_ticks;
  logic [STOP_LEN_W-1:0] mdl_stop_len;
  logic [STOP_SEQ_W-1:0] mdl_stop_seq;
  logic [BYTE_W-1:0]     mdl_held;
  logic                  mdl_held_v;
  logic [TICKS_W-1:0]    mdl_idle_cnt;
  logic [STOP_LEN_W-1:0] mdl_match;

  res_t frame_bytes_due[$];
  row_t dir_rows[$];
  logic dir_typed;
  res_t dir_exp;
  int unsigned mismatches;
  int unsigned live_items;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles;

  serial_frame_delimiter #(.MAX_STOP(MAX_STOP)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Effective stop length after saturation
  function automatic int unsigned stop_len_eff();
    return (mdl_stop_len > MAX_STOP) ? MAX_STOP : int'(mdl_stop_len);
  endfunction

  function automatic logic [BYTE_W-1:0] stop_byte_at(input int unsigned i);
    if (i >= STOP_SEQ_BYTES) return '0;
    return mdl_stop_seq[8*i +: 8];
  endfunction

  function automatic void frame_bytes_push(input logic [BYTE_W-1:0] b, input logic last);
    res_t r;
    r.out_byte = b;
    r.frame_last = last;
    frame_bytes_due.push_back(r);
  endfunction

  function automatic void reg_apply(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_FRAME_MODE: mdl_mode = val[MODE_W-1:0];
      REG_IDLE_TICKS: mdl_ticks = val[TICKS_W-1:0];
      REG_STOP_LENGTH: begin
        mdl_stop_len = val[STOP_LEN_W-1:0];
        mdl_match = '0;
      end
      default: begin
        mdl_stop_seq = val;
        mdl_match = '0;
      end
    endcase
  endfunction

  // Advance the framing state by one accepted transaction and queue its result
  function automatic void frame_predict(input logic func, input logic [BYTE_W-1:0] b);
    logic [MODE_W-1:0] mode;
    int unsigned len;
    int unsigned lim;
    int unsigned pos;
    mode = mdl_mode;
    len = stop_len_eff();
    if (func == FUNC_TICK) begin
      lim = (mdl_ticks == 0) ? 1 : int'(mdl_ticks);
      if (mdl_held_v) begin
        if (int'(mdl_idle_cnt) + 1 >= lim) begin
          mdl_held_v = 1'b0;
          mdl_idle_cnt = '0;
          frame_bytes_push(mdl_held, 1'b1);
        end else begin
          mdl_idle_cnt = mdl_idle_cnt + 1'b1;
        end
      end
    end else begin
      if (mode == MODE_STOP && len == 0) mode = MODE_IDLE;
      if (mode == MODE_IDLE) begin
        if (mdl_held_v) frame_bytes_push(mdl_held, 1'b0);
        mdl_held = b;
        mdl_held_v = 1'b1;
        mdl_idle_cnt = '0;
      end else if (mode == MODE_STOP) begin
        pos = mdl_match;
        if (pos >= len) pos = 0;
        if (b == stop_byte_at(pos)) pos = pos + 1;
        else if (b == stop_byte_at(0)) pos = 1;
        else pos = 0;
        if (pos >= len) begin
          mdl_match = '0;
          frame_bytes_push(b, 1'b1);
        end else begin
          mdl_match = pos[STOP_LEN_W-1:0];
          frame_bytes_push(b, 1'b0);
        end
      end else begin
        frame_bytes_push(b, 1'b1);
      end
    end
  endfunction

  // Check output transactions, then track accepted input and register writes
  always @(posedge clk) begin
    res_t e;
    int unsigned n0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (frame_bytes_due.size() == 0) begin
          $error("out_byte unexpected: actual %02h last %0b", m_tdata, m_tlast);
          mismatches++;
        end else begin
          e = frame_bytes_due.pop_front();
          if (m_tdata !== e.out_byte) begin
            $error("out_byte expected %02h actual %02h", e.out_byte, m_tdata);
            mismatches++;
          end
          if (m_tlast !== e.frame_last) begin
            $error("frame_last expected %0b actual %0b", e.frame_last, m_tlast);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        n0 = frame_bytes_due.size();
        frame_predict(s_tuser, s_tdata);
        if (dir_typed) begin
          if (frame_bytes_due.size() > n0) frame_bytes_due[frame_bytes_due.size()-1] = dir_exp;
          else frame_bytes_due.push_back(dir_exp);
        end
      end
      if (cfg_valid && cfg_ready) reg_apply(cfg_index, cfg_data);
    end
  end

  // Receiver backpressure
  always @(negedge clk) begin
    m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Present one input transaction; returns at the negedge after acceptance
  task automatic send_item(input logic func, input logic [BYTE_W-1:0] b,
                           input logic typed, input res_t exp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    if (func == FUNC_BYTE || mdl_held_v) live_items++;
    s_tvalid = 1'b1;
    s_tuser = func;
    s_tdata = b;
    dir_typed = typed;
    dir_exp = exp;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    dir_typed = 1'b0;
  endtask

  task automatic send_plain(input logic func, input logic [BYTE_W-1:0] b);
    send_item(func, b, 1'b0, '0);
  endtask

  // Hold off input until every expected result has drained
  task automatic wait_quiet();
    s_tvalid = 1'b0;
    while (frame_bytes_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    s_tvalid = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic void dir_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    row_t r;
    r = '{ROW_REG, idx, val, FUNC_BYTE, '0, 1'b0, '0};
    dir_rows.push_back(r);
  endfunction

  function automatic void dir_item(input logic func, input logic [BYTE_W-1:0] b,
                                   input logic typed, input logic [BYTE_W-1:0] eb,
                                   input logic el);
    row_t r;
    r = '{ROW_ITEM, '0, '0, func, b, typed, '0};
    r.exp.out_byte = eb;
    r.exp.frame_last = el;
    dir_rows.push_back(r);
  endfunction

  // One random register setting followed by traffic shaped for the chosen mode
  task automatic run_setting(input int unsigned n_items);
    logic [MODE_W-1:0] mode;
    logic [TICKS_W-1:0] ticks;
    logic [STOP_LEN_W-1:0] slen;
    logic [STOP_SEQ_W-1:0] seq;
    logic [BYTE_W-1:0] b;
    int unsigned r;
    int unsigned len;
    int unsigned lim;
    int unsigned brk;
    int unsigned start;
    r = $urandom_range(0, 99);
    mode = (r < 40) ? MODE_STOP : (r < 75) ? MODE_IDLE : (r < 90) ? MODE_PASS : MODE_SPARE;
    r = $urandom_range(0, 99);
    if (r < 25) ticks = 16'($urandom_range(1, 6));
    else if (r < 40) ticks = '0;
    else if (r < 50) ticks = 16'hFFFF;
    else if (r < 65) ticks = 16'($urandom);
    else ticks = 16'($urandom_range(1, 20));
    if (mode == MODE_STOP && $urandom_range(0, 99) < 85) slen = 3'($urandom_range(1, 4));
    else slen = 3'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    if (r < 40) begin
      seq = $urandom;
    end else if (r < 80) begin
      for (int i = 0; i < STOP_SEQ_BYTES; i++) begin
        case ($urandom_range(0, 3))
          0, 1: seq[8*i +: 8] = 8'h0D;
          2: seq[8*i +: 8] = 8'h0A;
          default: seq[8*i +: 8] = 8'($urandom);
        endcase
      end
    end else if (r < 90) begin
      seq = '0;
    end else begin
      seq = '1;
    end
    wait_quiet();
    write_reg(REG_FRAME_MODE, CFG_DATA_W'(mode));
    write_reg(REG_IDLE_TICKS, CFG_DATA_W'(ticks));
    write_reg(REG_STOP_SEQUENCE, seq);
    write_reg(REG_STOP_LENGTH, CFG_DATA_W'(slen));
    start = live_items;
    while (live_items - start < n_items) begin
      if ($urandom_range(0, 99) < 2) wait_quiet();
      len = stop_len_eff();
      lim = (mdl_ticks == 0) ? 1 : int'(mdl_ticks);
      if (mdl_mode == MODE_STOP && len > 0) begin
        // Noise, then a stop sequence that is sometimes broken
        repeat ($urandom_range(0, 3)) send_plain(FUNC_BYTE, 8'($urandom));
        brk = ($urandom_range(0, 99) < 15) ? $urandom_range(0, len - 1) : len;
        for (int i = 0; i < len; i++) begin
          if (i == brk) b = $urandom_range(0, 1) ? stop_byte_at(0) : 8'($urandom);
          else b = stop_byte_at(i);
          send_plain(FUNC_BYTE, b);
        end
        if ($urandom_range(0, 9) == 0) send_plain(FUNC_TICK, 8'($urandom));
      end else if (mdl_mode == MODE_IDLE || mdl_mode == MODE_STOP) begin
        // A burst of bytes, then ticks around the idle limit when it is small
        repeat ($urandom_range(1, 5)) send_plain(FUNC_BYTE, 8'($urandom));
        repeat ((lim <= 24) ? $urandom_range(0, lim + 1) : $urandom_range(0, 4))
          send_plain(FUNC_TICK, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) send_plain(FUNC_BYTE, 8'($urandom));
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(0, (lim < 4) ? lim + 1 : 4)) send_plain(FUNC_TICK, 8'($urandom));
      end
    end
  endtask

  initial begin
    row_t row;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = FUNC_BYTE;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_FRAME_MODE;
    cfg_data = '0;
    dir_typed = 1'b0;
    dir_exp = '0;
    mismatches = 0;
    live_items = 0;
    quiet_cycles = 0;
    send_idle_pct = 19;
    recv_idle_pct = 80;
    mdl_mode = MODE_PASS;
    mdl_ticks = IDLE_TICKS_RESET;
    mdl_stop_len = '0;
    mdl_stop_seq = '0;
    mdl_held = '0;
    mdl_held_v = 1'b0;
    mdl_idle_cnt = '0;
    mdl_match = '0;

    // Directed table: reset defaults, each mode and the corner cases
    dir_item(FUNC_BYTE, 8'h00, 1'b1, 8'h00, 1'b1);
    dir_item(FUNC_BYTE, 8'hFF, 1'b1, 8'hFF, 1'b1);
    dir_item(FUNC_TICK, 8'hC3, 1'b0, '0, 1'b0);           // tick with nothing held
    dir_reg(REG_FRAME_MODE, CFG_DATA_W'(MODE_IDLE));
    dir_item(FUNC_BYTE, 8'h5A, 1'b0, '0, 1'b0);
    dir_item(FUNC_BYTE, 8'hA5, 1'b1, 8'h5A, 1'b0);
    dir_reg(REG_IDLE_TICKS, 32'd0);                        // zero ticks acts as one
    dir_item(FUNC_TICK, 8'h00, 1'b1, 8'hA5, 1'b1);
    dir_item(FUNC_TICK, 8'hFF, 1'b0, '0, 1'b0);
    dir_reg(REG_IDLE_TICKS, 32'd2);
    dir_item(FUNC_BYTE, 8'h11, 1'b0, '0, 1'b0);
    dir_item(FUNC_TICK, 8'h00, 1'b0, '0, 1'b0);
    dir_item(FUNC_TICK, 8'h00, 1'b1, 8'h11, 1'b1);
    dir_reg(REG_FRAME_MODE, CFG_DATA_W'(MODE_STOP));       // empty stop sequence: idle
    dir_item(FUNC_BYTE, 8'h22, 1'b0, '0, 1'b0);
    dir_item(FUNC_BYTE, 8'h33, 1'b1, 8'h22, 1'b0);
    dir_reg(REG_STOP_SEQUENCE, 32'h0000_0A0D);
    dir_reg(REG_STOP_LENGTH, 32'd2);
    dir_item(FUNC_BYTE, 8'h0D, 1'b0, '0, 1'b0);            // mismatch restarts at first byte
    dir_item(FUNC_BYTE, 8'h0D, 1'b0, '0, 1'b0);
    dir_item(FUNC_BYTE, 8'h0A, 1'b0, '0, 1'b0);
    dir_item(FUNC_BYTE, 8'h0D, 1'b0, '0, 1'b0);
    dir_reg(REG_STOP_LENGTH, 32'd2);                       // rewrite clears the match
    dir_item(FUNC_BYTE, 8'h0A, 1'b0, '0, 1'b0);
    dir_item(FUNC_TICK, 8'h00, 1'b0, '0, 1'b0);            // held byte from idle mode
    dir_item(FUNC_TICK, 8'h00, 1'b0, '0, 1'b0);
    dir_reg(REG_STOP_SEQUENCE, 32'h4433_2211);
    dir_reg(REG_STOP_LENGTH, 32'd7);                       // saturates to the maximum
    dir_item(FUNC_BYTE, 8'h11, 1'b0, '0, 1'b0);
    dir_item(FUNC_BYTE, 8'h22, 1'b0, '0, 1'b0);
    dir_item(FUNC_BYTE, 8'h33, 1'b0, '0, 1'b0);
    dir_item(FUNC_BYTE, 8'h44, 1'b0, '0, 1'b0);
    dir_reg(REG_FRAME_MODE, CFG_DATA_W'(MODE_SPARE));      // unused selector passes through
    dir_item(FUNC_BYTE, 8'h80, 1'b1, 8'h80, 1'b1);
    dir_reg(REG_STOP_SEQUENCE, 32'hFFFF_FFFF);
    dir_reg(REG_IDLE_TICKS, 32'h0000_FFFF);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the directed table
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_REG) begin
        wait_quiet();
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        send_item(row.func, row.data, row.typed, row.exp);
      end
    end

    // Random traffic under three idling patterns
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 80 : 0;
      recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 19 : 0;
      repeat (5) run_setting(90);
    end

    // Drain and settle
    s_tvalid = 1'b0;
    while (frame_bytes_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- serial_frame_delimiter.f -----
rtl/core/sfd_pkg.sv
rtl/core/sfd_cfg.sv
rtl/core/sfd_frame.sv
rtl/core/sfd_out.sv
rtl/core/serial_frame_delimiter.sv
verif/tb.sv
